[hw/rtl/assert_macros.svh]
// Concurrent assertion helpers, clocked on the rising edge and off during reset.
// Build with NO_ASSERTIONS defined to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/rgbhsl_pkg.sv]
package rgbhsl_pkg;

	localparam int CH_W      = 8;
	localparam int HUE_W     = 15;
	localparam int Q15_W     = 16;
	localparam int Q15_FRAC  = 15;

	localparam int HUE_FULL  = 23040;
	localparam int HUE_SIXTH = 3840;

	// lightness = 64*sum + floor((128*sum + 255) / 510), 510 done by reciprocal
	localparam int LIGHT_DIV   = 510;
	localparam int LIGHT_RECIP = 8224;
	localparam int LIGHT_SHIFT = 22;
	localparam int LIGHT_PW    = 30;

	// quotient pipes (hue and saturation share these sizes): one quotient bit per step
	localparam int DIV_QW = 16;
	localparam int DIV_DW = 8;
	localparam int DIV_NW = DIV_QW + DIV_DW;

	// stage map of the whole pipe
	localparam int ST_FRONT_LAST  = 3;
	localparam int ST_LIGHT_FIRST = 3;
	localparam int ST_LIGHT_LAST  = 6;
	localparam int ST_DIV_FIRST   = 4;
	localparam int ST_DIV_LAST    = ST_DIV_FIRST + DIV_QW;
	localparam int PIPE_DEPTH     = ST_DIV_LAST + 1;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [Q15_W-1:0] lightness;
		logic [Q15_W-1:0] saturation;
	} hsl_t;

endpackage

[hw/rtl/rgbhsl_if.sv]
interface rgbhsl_pix_if;
	import rgbhsl_pkg::*;

	logic valid;
	logic ready;
	pix_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rgbhsl_hsl_if;
	import rgbhsl_pkg::*;

	logic valid;
	logic ready;
	hsl_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rgbhsl_front.sv]
module rgbhsl_front (
	input  logic                             clk,
	input  logic [rgbhsl_pkg::ST_FRONT_LAST:1] en,
	input  rgbhsl_pkg::pix_t                 pix,
	output logic [rgbhsl_pkg::CH_W:0]        sum_s2,
	output logic [rgbhsl_pkg::DIV_NW-1:0]    num_h_s3,
	output logic [rgbhsl_pkg::DIV_DW-1:0]    den_h_s3,
	output logic [rgbhsl_pkg::DIV_NW-1:0]    num_s_s3,
	output logic [rgbhsl_pkg::DIV_DW-1:0]    den_s_s3,
	output logic                             grey_s3
);
	import rgbhsl_pkg::*;

	logic [CH_W-1:0] mx, mn;
	sector_t         sec;
	logic [CH_W:0]   diff;

	logic [CH_W-1:0] mx_s1, mn_s1;
	sector_t         sec_s1;
	logic [CH_W:0]   diff_s1;

	logic [CH_W:0]   sum;
	logic [CH_W:0]   den_hi;
	logic [CH_W-1:0] d, den;
	logic [CH_W+1:0] base;
	logic [CH_W+2:0] d6;
	logic [CH_W+3:0] k, k_wrap;

	logic [CH_W-1:0] d_s2, den_s2;
	logic [CH_W+2:0] m_s2;
	logic            grey_s2;

	// stage 1: max, min, sector and the channel difference of that sector
	always_comb begin
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			sec  = SEC_RED;
			mx   = pix.red;
			diff = {1'b0, pix.green} - {1'b0, pix.blue};
		end else if (pix.green >= pix.blue) begin
			sec  = SEC_GREEN;
			mx   = pix.green;
			diff = {1'b0, pix.blue} - {1'b0, pix.red};
		end else begin
			sec  = SEC_BLUE;
			mx   = pix.blue;
			diff = {1'b0, pix.red} - {1'b0, pix.green};
		end
		if (pix.red <= pix.green && pix.red <= pix.blue) begin
			mn = pix.red;
		end else if (pix.green <= pix.blue) begin
			mn = pix.green;
		end else begin
			mn = pix.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mx_s1   <= mx;
			mn_s1   <= mn;
			sec_s1  <= sec;
			diff_s1 <= diff;
		end
	end

	// stage 2: sum, delta, saturation divisor and hue in sixths of a turn times delta
	always_comb begin
		sum    = {1'b0, mx_s1} + {1'b0, mn_s1};
		d      = mx_s1 - mn_s1;
		den_hi = (CH_W+1)'(2 * LIGHT_DIV / 2) - sum;
		den    = sum[CH_W] ? den_hi[CH_W-1:0] : sum[CH_W-1:0];
		case (sec_s1)
			SEC_GREEN: base = {1'b0, d, 1'b0};
			SEC_BLUE:  base = {d, 2'b00};
			default:   base = '0;
		endcase
		d6     = (CH_W+3)'({d, 2'b00}) + (CH_W+3)'({d, 1'b0});
		k      = (CH_W+4)'(base) + {{3{diff_s1[CH_W]}}, diff_s1};
		// a negative hue goes once round the circle
		k_wrap = k[CH_W+3] ? k + {1'b0, d6} : k;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sum_s2  <= sum;
			d_s2    <= d;
			den_s2  <= den;
			m_s2    <= k_wrap[CH_W+2:0];
			grey_s2 <= (mx_s1 == mn_s1);
		end
	end

	// stage 3: dividends and divisors for the quotient pipes
	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_h_s3 <= DIV_NW'(m_s2) * DIV_NW'(HUE_SIXTH);
			den_h_s3 <= d_s2;
			num_s_s3 <= DIV_NW'(d_s2) << Q15_FRAC;
			den_s_s3 <= den_s2;
			grey_s3  <= grey_s2;
		end
	end

endmodule

[hw/rtl/rgbhsl_light.sv]
module rgbhsl_light (
	input  logic                                  clk,
	input  logic [rgbhsl_pkg::ST_LIGHT_LAST:rgbhsl_pkg::ST_LIGHT_FIRST] en,
	input  logic [rgbhsl_pkg::CH_W:0]             sum,
	output logic [rgbhsl_pkg::Q15_W-1:0]          light_s6
);
	import rgbhsl_pkg::*;

	logic [Q15_W-1:0]    y;
	logic [Q15_W-1:0]    y_s3, y_s4;
	logic [LIGHT_PW-1:0] p_s3;
	logic [CH_W:0]       sum_s3, sum_s4, sum_s5;
	logic [CH_W-1:0]     q0_s4, q_s5;
	logic [Q15_W-1:0]    rem;

	assign y = Q15_W'({sum, 7'b0}) + Q15_W'(LIGHT_DIV / 2);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			y_s3   <= y;
			p_s3   <= LIGHT_PW'(y) * LIGHT_PW'(LIGHT_RECIP);
			sum_s3 <= sum;
		end
	end

	// estimate is low by at most one
	always_ff @(posedge clk) begin
		if (en[4]) begin
			q0_s4  <= CH_W'(p_s3 >> LIGHT_SHIFT);
			y_s4   <= y_s3;
			sum_s4 <= sum_s3;
		end
	end

	assign rem = y_s4 - Q15_W'(q0_s4) * Q15_W'(LIGHT_DIV);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			q_s5   <= q0_s4 + CH_W'(rem >= Q15_W'(LIGHT_DIV));
			sum_s5 <= sum_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			light_s6 <= Q15_W'({sum_s5, 6'b0}) + Q15_W'(q_s5);
		end
	end

endmodule

[hw/rtl/rgbhsl_div.sv]
module rgbhsl_div (
	input  logic                          clk,
	input  logic [rgbhsl_pkg::DIV_QW:0]   en,
	input  logic [rgbhsl_pkg::DIV_NW-1:0] num,
	input  logic [rgbhsl_pkg::DIV_DW-1:0] den,
	output logic [rgbhsl_pkg::DIV_QW-1:0] quo
);
	import rgbhsl_pkg::*;

	// index is the step; dividend low bits shift out as quotient bits shift in
	logic [DIV_DW-1:0] rem_s [DIV_QW];
	logic [DIV_QW-1:0] acc_s [DIV_QW];
	logic [DIV_DW-1:0] dvs_s [DIV_QW];

	logic [DIV_DW:0]   rem2;
	logic              up;

	for (genvar j = 0; j < DIV_QW; j++) begin : g_step
		logic [DIV_DW-1:0] rem_in, dvs_in;
		logic [DIV_QW-1:0] acc_in;
		logic [DIV_DW:0]   trial, sub;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_in = num[DIV_NW-1:DIV_QW];
			assign acc_in = num[DIV_QW-1:0];
			assign dvs_in = den;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign acc_in = acc_s[j-1];
			assign dvs_in = dvs_s[j-1];
		end

		assign trial = {rem_in, acc_in[DIV_QW-1]};
		assign ge    = trial >= {1'b0, dvs_in};
		assign sub   = trial - {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= ge ? sub[DIV_DW-1:0] : trial[DIV_DW-1:0];
				acc_s[j] <= {acc_in[DIV_QW-2:0], ge};
				dvs_s[j] <= dvs_in;
			end
		end
	end

	// round to nearest: up when twice the remainder reaches the divisor
	assign rem2 = {rem_s[DIV_QW-1], 1'b0};
	assign up   = rem2 >= {1'b0, dvs_s[DIV_QW-1]};

	always_ff @(posedge clk) begin
		if (en[DIV_QW]) begin
			quo <= acc_s[DIV_QW-1] + DIV_QW'(up);
		end
	end

endmodule

[hw/rtl/rgb_to_hsl_converter_core.sv]
// RGB to HSL converter, fully pipelined.
// Throughput: one pixel per clock while hsl is ready; each of the two quotient pipes
// (hue and saturation) retires one quotient bit per step stage.
// Reset clears only the stage valid bits; data registers are not reset.
`include "assert_macros.svh"

module rgb_to_hsl_converter_core (
	input  logic         clk,
	input  logic         arst_n,
	rgbhsl_pix_if.sink   pixel,
	rgbhsl_hsl_if.source hsl
);
	import rgbhsl_pkg::*;

	logic [PIPE_DEPTH:1]   stage_vld_q;
	logic [PIPE_DEPTH:1]   en;

	logic [CH_W:0]         sum_s2;
	logic [DIV_NW-1:0]     num_h_s3, num_s_s3;
	logic [DIV_DW-1:0]     den_h_s3, den_s_s3;
	logic                  grey_s3;
	logic [Q15_W-1:0]      light_s6;
	logic [DIV_QW-1:0]     hq_s20, sq_s20;

	logic                  grey_d  [PIPE_DEPTH-1:ST_DIV_FIRST];
	logic [Q15_W-1:0]      light_d [PIPE_DEPTH-1:ST_LIGHT_LAST+1];

	logic [DIV_QW-1:0]     hue_wrap;
	hsl_t                  out_s21;

	// a stage loads when it or any stage after it is empty, or when hsl is ready
	for (genvar i = 1; i <= PIPE_DEPTH; i++) begin : g_en
		assign en[i] = hsl.ready || !(&stage_vld_q[PIPE_DEPTH:i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			stage_vld_q <= (en & {stage_vld_q[PIPE_DEPTH-1:1], pixel.valid})
				| (~en & stage_vld_q);
		end
	end

	assign pixel.ready = en[1];

	rgbhsl_front u_front (
		.clk      (clk),
		.en       (en[ST_FRONT_LAST:1]),
		.pix      (pixel.data),
		.sum_s2   (sum_s2),
		.num_h_s3 (num_h_s3),
		.den_h_s3 (den_h_s3),
		.num_s_s3 (num_s_s3),
		.den_s_s3 (den_s_s3),
		.grey_s3  (grey_s3)
	);

	rgbhsl_light u_light (
		.clk      (clk),
		.en       (en[ST_LIGHT_LAST:ST_LIGHT_FIRST]),
		.sum      (sum_s2),
		.light_s6 (light_s6)
	);

	rgbhsl_div u_div_hue (
		.clk (clk),
		.en  (en[ST_DIV_LAST:ST_DIV_FIRST]),
		.num (num_h_s3),
		.den (den_h_s3),
		.quo (hq_s20)
	);

	rgbhsl_div u_div_sat (
		.clk (clk),
		.en  (en[ST_DIV_LAST:ST_DIV_FIRST]),
		.num (num_s_s3),
		.den (den_s_s3),
		.quo (sq_s20)
	);

	// carry grey flag and lightness alongside the quotient pipes
	for (genvar i = ST_DIV_FIRST; i < PIPE_DEPTH; i++) begin : g_grey
		always_ff @(posedge clk) begin
			if (en[i]) begin
				grey_d[i] <= (i == ST_DIV_FIRST) ? grey_s3 : grey_d[(i == ST_DIV_FIRST) ? i : i-1];
			end
		end
	end

	for (genvar i = ST_LIGHT_LAST + 1; i < PIPE_DEPTH; i++) begin : g_light
		always_ff @(posedge clk) begin
			if (en[i]) begin
				light_d[i] <= (i == ST_LIGHT_LAST + 1) ? light_s6
					: light_d[(i == ST_LIGHT_LAST + 1) ? i : i-1];
			end
		end
	end

	// full turn wraps to zero
	assign hue_wrap = (hq_s20 >= DIV_QW'(HUE_FULL)) ? hq_s20 - DIV_QW'(HUE_FULL) : hq_s20;

	always_ff @(posedge clk) begin
		if (en[PIPE_DEPTH]) begin
			out_s21.hue        <= grey_d[PIPE_DEPTH-1] ? '0 : hue_wrap[HUE_W-1:0];
			out_s21.lightness  <= light_d[PIPE_DEPTH-1];
			out_s21.saturation <= grey_d[PIPE_DEPTH-1] ? '0 : sq_s20;
		end
	end

	assign hsl.valid = stage_vld_q[PIPE_DEPTH];
	assign hsl.data  = out_s21;

	`ASSERT_PROP(a_ready_when_tail_free, clk, arst_n, !stage_vld_q[PIPE_DEPTH] |-> pixel.ready)
	`ASSERT_IMPLY(a_light_range, clk, arst_n, hsl.valid, hsl.data.lightness <= 16'd32768)
	`ASSERT_IMPLY(a_hue_range, clk, arst_n, hsl.valid, hsl.data.hue < 15'd23040)
	`ASSERT_IMPLY(a_grey_hue, clk, arst_n, hsl.valid && hsl.data.saturation == '0, hsl.data.hue == '0)

endmodule
